// ===== hdl/hrcd_pkg.sv =====
// Package for the HTTP request completion detector.
// Holds the word types, character codes and small helper functions.
// Has no dependencies; used by hrcd_core and the top level.
package hrcd_pkg;

    localparam int unsigned LENGTH_BITS   = 32;
    localparam int unsigned NAME_LEN      = 15;
    localparam int unsigned NAME_POS_BITS = 5;
    localparam int unsigned TERM_BITS     = 2;

    localparam logic [NAME_POS_BITS-1:0] NAME_FAILED = NAME_POS_BITS'(16);
    localparam logic [NAME_POS_BITS-1:0] NAME_DONE   = NAME_POS_BITS'(NAME_LEN);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Progress through the CR LF CR LF terminator.
    typedef enum logic [TERM_BITS-1:0] {
        TERM_NONE   = 2'd0,
        TERM_CR     = 2'd1,
        TERM_CRLF   = 2'd2,
        TERM_CRLFCR = 2'd3
    } t_term;

    typedef enum logic [1:0] {
        VP_IDLE      = 2'd0,
        VP_EXPECT    = 2'd1,
        VP_AFTER_PLUS = 2'd2,
        VP_DIGITS    = 2'd3
    } t_value_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_word;

    typedef struct packed {
        logic        complete;
        logic        header_done;
        logic [31:0] content_length;
        logic [31:0] body_bytes;
    } t_out_word;

    // Characters of "content-length:" in lower case.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

// ===== hdl/hrcd_core.sv =====
// Parser state and per-byte update of the completion detector.
// Depends on hrcd_pkg; the result is combinational from the next state.
module hrcd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  hrcd_pkg::t_in_word  i_word,
    output hrcd_pkg::t_out_word o_result
);

    localparam int unsigned LB = hrcd_pkg::LENGTH_BITS;

    hrcd_pkg::t_term                      r_term, n_term;
    logic                                 r_hdr_end, n_hdr_end;
    logic [hrcd_pkg::NAME_POS_BITS-1:0]   r_pos, n_pos;
    hrcd_pkg::t_value_phase               r_vp, n_vp;
    logic                                 r_taken, n_taken;
    logic [LB-1:0]                        r_acc, n_acc;
    logic                                 r_inv, n_inv;
    logic [LB-1:0]                        r_body, n_body;

    // Current state, as seen by this byte (cleared on the first byte of a request).
    hrcd_pkg::t_term                      s_term;
    logic                                 s_hdr_end;
    logic [hrcd_pkg::NAME_POS_BITS-1:0]   s_pos;
    hrcd_pkg::t_value_phase               s_vp;
    logic                                 s_taken;
    logic [LB-1:0]                        s_acc;
    logic                                 s_inv;
    logic [LB-1:0]                        s_body;

    logic [7:0]    b;
    logic          is_digit;
    logic [LB+3:0] acc_ext;
    logic [LB+3:0] acc_next;
    logic          acc_ovf;
    logic [LB-1:0] len;
    logic [63:0]   len_ext;
    logic [63:0]   body_ext;

    assign b        = i_word.data_byte;
    assign is_digit = (b >= hrcd_pkg::CH_ZERO) && (b <= hrcd_pkg::CH_NINE);

    always_comb begin
        if (i_word.first_byte) begin
            s_term    = hrcd_pkg::TERM_NONE;
            s_hdr_end = 1'b0;
            s_pos     = '0;
            s_vp      = hrcd_pkg::VP_IDLE;
            s_taken   = 1'b0;
            s_acc     = '0;
            s_inv     = 1'b0;
            s_body    = '0;
        end else begin
            s_term    = r_term;
            s_hdr_end = r_hdr_end;
            s_pos     = r_pos;
            s_vp      = r_vp;
            s_taken   = r_taken;
            s_acc     = r_acc;
            s_inv     = r_inv;
            s_body    = r_body;
        end
    end

    // acc * 10 + digit by shifts; any bit above the length width is an overflow.
    assign acc_ext  = {4'b0000, s_acc};
    assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (LB + 4)'(b - hrcd_pkg::CH_ZERO);
    assign acc_ovf  = |acc_next[LB+3:LB];

    always_comb begin
        n_term    = s_term;
        n_hdr_end = s_hdr_end;
        n_pos     = s_pos;
        n_vp      = s_vp;
        n_taken   = s_taken;
        n_acc     = s_acc;
        n_inv     = s_inv;
        n_body    = s_body;

        if (!s_hdr_end) begin
            // Header line parsing.
            if (b == hrcd_pkg::CH_LF) begin
                if (s_vp == hrcd_pkg::VP_EXPECT || s_vp == hrcd_pkg::VP_AFTER_PLUS) begin
                    n_inv = 1'b1;
                end
                n_vp  = hrcd_pkg::VP_IDLE;
                n_pos = '0;
            end else if (s_vp != hrcd_pkg::VP_IDLE) begin
                if (hrcd_pkg::is_blank(b)) begin
                    n_vp = s_vp;
                end else if (is_digit) begin
                    if (acc_ovf) begin
                        n_inv = 1'b1;
                        n_vp  = hrcd_pkg::VP_IDLE;
                    end else begin
                        n_acc = acc_next[LB-1:0];
                        n_vp  = hrcd_pkg::VP_DIGITS;
                    end
                end else if (s_vp == hrcd_pkg::VP_EXPECT && b == hrcd_pkg::CH_PLUS) begin
                    n_vp = hrcd_pkg::VP_AFTER_PLUS;
                end else begin
                    if (s_vp != hrcd_pkg::VP_DIGITS) begin
                        n_inv = 1'b1;
                    end
                    n_vp = hrcd_pkg::VP_IDLE;
                end
            end else if (!s_taken && s_pos < hrcd_pkg::NAME_DONE) begin
                if (hrcd_pkg::to_lower(b) == hrcd_pkg::name_char(s_pos[3:0])) begin
                    n_pos = s_pos + 1'b1;
                    if (s_pos == hrcd_pkg::NAME_DONE - 1'b1) begin
                        n_taken = 1'b1;
                        n_acc   = '0;
                        n_inv   = 1'b0;
                        n_vp    = hrcd_pkg::VP_EXPECT;
                    end
                end else begin
                    n_pos = hrcd_pkg::NAME_FAILED;
                end
            end

            // Blank line detection.
            if (b == hrcd_pkg::CH_CR) begin
                n_term = (s_term == hrcd_pkg::TERM_CRLF) ? hrcd_pkg::TERM_CRLFCR
                                                         : hrcd_pkg::TERM_CR;
            end else if (b == hrcd_pkg::CH_LF && s_term == hrcd_pkg::TERM_CR) begin
                n_term = hrcd_pkg::TERM_CRLF;
            end else if (b == hrcd_pkg::CH_LF && s_term == hrcd_pkg::TERM_CRLFCR) begin
                n_term    = hrcd_pkg::TERM_NONE;
                n_hdr_end = 1'b1;
            end else begin
                n_term = hrcd_pkg::TERM_NONE;
            end
        end else if (!(&s_body)) begin
            n_body = s_body + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term    <= hrcd_pkg::TERM_NONE;
            r_hdr_end <= 1'b0;
            r_pos     <= '0;
            r_vp      <= hrcd_pkg::VP_IDLE;
            r_taken   <= 1'b0;
            r_acc     <= '0;
            r_inv     <= 1'b0;
            r_body    <= '0;
        end else if (i_step) begin
            r_term    <= n_term;
            r_hdr_end <= n_hdr_end;
            r_pos     <= n_pos;
            r_vp      <= n_vp;
            r_taken   <= n_taken;
            r_acc     <= n_acc;
            r_inv     <= n_inv;
            r_body    <= n_body;
        end
    end

    assign len      = n_inv ? '0 : n_acc;
    assign len_ext  = 64'(len);
    assign body_ext = 64'(n_body);

    always_comb begin
        o_result.complete       = n_hdr_end &&
                                  (((len == '0) && (n_body == '0)) ||
                                   ((len != '0) && (n_body >= len)));
        o_result.header_done    = n_hdr_end;
        o_result.content_length = n_hdr_end ? len_ext[31:0] : 32'd0;
        o_result.body_bytes     = body_ext[31:0];
    end

endmodule

// ===== hdl/http_request_completion_detector.sv =====
// Top level of the HTTP request completion detector.
// Depends on hrcd_pkg and hrcd_core.
//
// Usage: one request byte enters per input word, with first_byte set on the
// first byte of each new request. Every input word produces exactly one
// output word giving complete, header_done, the parsed content length and
// the saturating body byte count after that byte.
// Both channels use valid/ready. An accepted word is held in the input
// register; when it advances, the parser state is updated and the result
// is written to the output register, which raises o_out_valid. One word
// per cycle is sustained while the receiver takes every result; the
// parser state is updated once for each word as it advances.
// When the receiver stalls, the result stays in the output register and one
// further word waits in the input register before o_in_ready falls; nothing
// is dropped. Reset clears both registers' valid flags and all parser state,
// as if a new request had begun.
module http_request_completion_detector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hrcd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hrcd_pkg::t_out_word o_out_word
);

    logic                r_in_valid;
    hrcd_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    hrcd_pkg::t_out_word r_out_word;
    hrcd_pkg::t_out_word result;
    logic                advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    hrcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The length is only reported once the header has ended.
    a_len_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.header_done || r_out_word.content_length == 32'd0))
        else $error("content_length reported before header end");

    a_complete_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_word.complete || r_out_word.header_done))
        else $error("complete without header end");

    a_body_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.header_done || r_out_word.body_bytes == 32'd0))
        else $error("body bytes counted before header end");

    // A held word in the input register must not vanish while the output is stalled.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word lost");

endmodule

// ===== bench/hrcd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the HTTP request completion detector: follows both channels,
// predicts the result word of every accepted byte and compares it field by field.
// Depends on hrcd_pkg for the word types, character codes and state encodings.
module hrcd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  hrcd_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hrcd_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [63:0] LEN_CEIL = (64'd1 << hrcd_pkg::LENGTH_BITS) - 64'd1;
    localparam logic [8*hrcd_pkg::NAME_LEN-1:0] LENGTH_FIELD = "content-length:";

    // Parser state of the request being followed.
    hrcd_pkg::t_term          term_state;
    logic                     header_over;
    logic [4:0]               name_pos;
    hrcd_pkg::t_value_phase   value_phase;
    logic                     length_seen;
    logic [63:0]              length_acc;
    logic                     length_void;
    logic [63:0]              body_count;

    hrcd_pkg::t_out_word      result_queue[$];
    int                       fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic clear_request();
        term_state  = hrcd_pkg::TERM_NONE;
        header_over = 1'b0;
        name_pos    = '0;
        value_phase = hrcd_pkg::VP_IDLE;
        length_seen = 1'b0;
        length_acc  = '0;
        length_void = 1'b0;
        body_count  = '0;
    endtask

    task automatic report_mismatch(input string what);
        if (fail_total < 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    // Advances the parser by one byte and gives the result word it should produce.
    task automatic step_request(input hrcd_pkg::t_in_word w,
                                output hrcd_pkg::t_out_word res);
        logic [7:0]  b;
        logic [7:0]  lc;
        logic        digit;
        logic        blank;
        logic [63:0] digit_val;
        logic [63:0] len;
        b = w.data_byte;
        if (w.first_byte) begin
            clear_request();
        end
        if (!header_over) begin
            digit = (b >= hrcd_pkg::CH_ZERO) && (b <= hrcd_pkg::CH_NINE);
            blank = (b == hrcd_pkg::CH_SPACE) || (b == hrcd_pkg::CH_TAB) ||
                    (b == hrcd_pkg::CH_VT) || (b == hrcd_pkg::CH_FF) ||
                    (b == hrcd_pkg::CH_CR);
            if (b == hrcd_pkg::CH_LF) begin
                // A line ending before any digit leaves the value unusable.
                if (value_phase == hrcd_pkg::VP_EXPECT ||
                    value_phase == hrcd_pkg::VP_AFTER_PLUS) begin
                    length_void = 1'b1;
                end
                value_phase = hrcd_pkg::VP_IDLE;
                name_pos    = '0;
            end else if (value_phase != hrcd_pkg::VP_IDLE) begin
                if (!blank) begin
                    if (digit) begin
                        digit_val = 64'(b - hrcd_pkg::CH_ZERO);
                        if (length_acc > (LEN_CEIL - digit_val) / 64'd10) begin
                            length_void = 1'b1;
                            value_phase = hrcd_pkg::VP_IDLE;
                        end else begin
                            length_acc  = length_acc * 64'd10 + digit_val;
                            value_phase = hrcd_pkg::VP_DIGITS;
                        end
                    end else if (value_phase == hrcd_pkg::VP_EXPECT &&
                                 b == hrcd_pkg::CH_PLUS) begin
                        value_phase = hrcd_pkg::VP_AFTER_PLUS;
                    end else begin
                        if (value_phase != hrcd_pkg::VP_DIGITS) begin
                            length_void = 1'b1;
                        end
                        value_phase = hrcd_pkg::VP_IDLE;
                    end
                end
            end else if (!length_seen && name_pos < hrcd_pkg::NAME_LEN) begin
                lc = (b >= hrcd_pkg::CH_UP_A && b <= hrcd_pkg::CH_UP_Z) ? b + 8'd32 : b;
                if (lc == LENGTH_FIELD[8*(hrcd_pkg::NAME_LEN-1-int'(name_pos)) +: 8]) begin
                    name_pos++;
                    if (name_pos == hrcd_pkg::NAME_LEN) begin
                        length_seen = 1'b1;
                        length_acc  = '0;
                        length_void = 1'b0;
                        value_phase = hrcd_pkg::VP_EXPECT;
                    end
                end else begin
                    name_pos = hrcd_pkg::NAME_FAILED;
                end
            end

            if (b == hrcd_pkg::CH_CR) begin
                term_state = (term_state == hrcd_pkg::TERM_CRLF) ? hrcd_pkg::TERM_CRLFCR
                                                                 : hrcd_pkg::TERM_CR;
            end else if (b == hrcd_pkg::CH_LF && term_state == hrcd_pkg::TERM_CR) begin
                term_state = hrcd_pkg::TERM_CRLF;
            end else if (b == hrcd_pkg::CH_LF && term_state == hrcd_pkg::TERM_CRLFCR) begin
                term_state  = hrcd_pkg::TERM_NONE;
                header_over = 1'b1;
            end else begin
                term_state = hrcd_pkg::TERM_NONE;
            end
        end else if (body_count < LEN_CEIL) begin
            body_count++;
        end

        len = length_void ? 64'd0 : length_acc;
        res.complete       = header_over &&
                             ((len == 0 && body_count == 0) || (len != 0 && body_count >= len));
        res.header_done    = header_over;
        res.content_length = header_over ? len[31:0] : 32'd0;
        res.body_bytes     = body_count[31:0];
    endtask

    always @(posedge i_clk) begin : follow_channels
        hrcd_pkg::t_out_word want;
        hrcd_pkg::t_out_word seen;
        if (!i_rst_n) begin
            clear_request();
            result_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = i_out_word;
                if (result_queue.size() == 0) begin
                    report_mismatch("result word with no request byte waiting");
                end else begin
                    want = result_queue.pop_front();
                    if (seen.complete !== want.complete) begin
                        report_mismatch($sformatf("complete got %0b want %0b",
                                                  seen.complete, want.complete));
                    end
                    if (seen.header_done !== want.header_done) begin
                        report_mismatch($sformatf("header_done got %0b want %0b",
                                                  seen.header_done, want.header_done));
                    end
                    if (seen.content_length !== want.content_length) begin
                        report_mismatch($sformatf("content_length got %0d want %0d",
                                                  seen.content_length, want.content_length));
                    end
                    if (seen.body_bytes !== want.body_bytes) begin
                        report_mismatch($sformatf("body_bytes got %0d want %0d",
                                                  seen.body_bytes, want.body_bytes));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_request(i_in_word, want);
                result_queue.push_back(want);
            end
        end
        o_pending <= result_queue.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the bench for the HTTP request completion detector: drives request bytes,
// paces the result channel and gives the verdict. Depends on hrcd_pkg and hrcd_checker.
module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int WORD_TARGET = 1000;
    localparam int CALM_FROM   = 850;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    hrcd_pkg::t_in_word  in_word   = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    hrcd_pkg::t_out_word out_word;
    int                  fail_count;
    int                  pending;

    int         words_sent  = 0;
    int         quiet       = 0;
    logic       hold_asked  = 1'b0;
    logic       hold_served = 1'b0;
    logic       pause_done  = 1'b0;
    logic [7:0] req_bytes[$];

    always #4 clk = ~clk;

    http_request_completion_detector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    hrcd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gives up when neither channel has moved a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic first);
        int gap;
        if (words_sent == 300) begin
            hold_asked = 1'b1;
        end
        // Once, let the block drain completely before carrying on.
        if (words_sent >= 600 && !pause_done) begin
            pause_done = 1'b1;
            in_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
        end
        if (words_sent < CALM_FROM && (words_sent % 192) < 128 &&
            $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= hrcd_pkg::t_in_word'{data_byte: b, first_byte: first};
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            req_bytes.push_back(s[k]);
        end
    endtask

    task automatic add_blanks(input int most);
        logic [7:0] blank_set[5];
        int n;
        blank_set = '{hrcd_pkg::CH_SPACE, hrcd_pkg::CH_TAB, hrcd_pkg::CH_VT,
                      hrcd_pkg::CH_FF, hrcd_pkg::CH_CR};
        n = $urandom_range(0, most);
        repeat (n) req_bytes.push_back(blank_set[$urandom_range(0, 4)]);
    endtask

    // One content-length line with random case, sign, spacing, digits and tail.
    task automatic add_length_line(output int unsigned body_want);
        string       field;
        string       digits;
        logic [7:0]  c;
        int          spoil;
        int unsigned pick;
        field = "content-length:";
        spoil = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 14)) : -1;
        for (int k = 0; k < field.len(); k++) begin
            c = field[k];
            if (k == spoil) begin
                c = "x";
            end else if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
                c = c - 8'd32;
            end
            req_bytes.push_back(c);
        end
        add_blanks(2);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            add_text("+");
        end else if (pick < 26) begin
            add_text("-");
        end else if (pick < 31) begin
            add_text("++");
        end else if (pick < 34) begin
            add_text("+-");
        end else if (pick < 38) begin
            add_text("a");
        end
        add_blanks(1);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            digits = "";
        end else if (pick < 10) begin
            digits = "4294967295";
        end else if (pick < 14) begin
            digits = "4294967296";
        end else if (pick < 16) begin
            digits = "18446744073709551616";
        end else if (pick < 20) begin
            digits = $sformatf("%0d", $urandom);
        end else begin
            digits = $sformatf("%0d", $urandom_range(0, 24));
        end
        if (digits.len() > 0 && $urandom_range(0, 9) == 0) begin
            digits = {"00", digits};
        end
        for (int k = 0; k < digits.len(); k++) begin
            req_bytes.push_back(digits[k]);
            if ($urandom_range(0, 15) == 0) begin
                add_blanks(1);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            add_text(";q");
        end else if (pick == 2) begin
            add_text("x7");
        end else if (pick == 3) begin
            add_blanks(2);
        end
        add_text("\r\n");
        if (digits.len() > 0 && digits.len() <= 4) begin
            body_want = digits.atoi();
        end else begin
            body_want = $urandom_range(0, 6);
        end
    endtask

    // A whole request, body included, or now and then a burst of raw noise.
    task automatic build_request();
        int unsigned body_want;
        int unsigned ignored;
        int unsigned body_len;
        int unsigned n;
        req_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(3, 30);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    req_bytes.push_back(($urandom_range(0, 1) == 1) ? hrcd_pkg::CH_CR
                                                                     : hrcd_pkg::CH_LF);
                end else begin
                    req_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            add_text("GET /\r\n");
        end else begin
            add_text("POST /x\r\n");
        end
        if ($urandom_range(0, 3) == 0) begin
            add_text("Content-Type: t\r\n");
        end
        body_want = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 8) begin
            add_length_line(body_want);
        end
        if ($urandom_range(0, 4) == 0) begin
            add_length_line(ignored);
        end
        if ($urandom_range(0, 5) == 0) begin
            add_text("Host: h\r\r\n");
        end
        add_text("\r\n");
        body_len = body_want + $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
            body_len = $urandom_range(0, body_want);
        end
        repeat (body_len) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_request(input logic fresh);
        for (int k = 0; k < req_bytes.size(); k++) begin
            send_word(req_bytes[k], (k == 0) ? fresh : ($urandom_range(0, 299) == 0));
        end
    endtask

    // Result side: short random stalls, one long hold-off, and none near the end.
    initial begin : result_side
        int gap;
        wait (rst_n == 1'b1);
        forever begin
            @(posedge clk);
            if (hold_asked && !hold_served) begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end else if (words_sent < CALM_FROM && (words_sent % 192) >= 64 &&
                         $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin : request_side
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mixed-case name, plus sign, body bytes at both ends of the range,
        // then a third body byte that completes the request.
        req_bytes.delete();
        add_text("Content-Length:+3\r\n\r\n");
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'hFF);
        add_text("a");
        send_request(1'b1);

        while (words_sent < WORD_TARGET) begin
            build_request();
            send_request($urandom_range(0, 19) != 0);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
